[hdl/rgbbl_pkg.sv]
// Shared types, constants and channel helpers for the RGB565 blend pipeline.
// No dependencies; the stage modules, the top level and the testbench import this package.
`default_nettype none

package rgbbl_pkg;

   // Marker for "no colour": disables tinting and the transparent key
   localparam logic [15:0] NO_COLOR   = 16'hFFFF;
   localparam logic [7:0]  FULL_ALPHA = 8'd255;

   // Register indexes on the csr channel
   typedef enum logic [1:0] {
      CSR_ALPHA = 2'd0,
      CSR_TINT  = 2'd1,
      CSR_MODE  = 2'd2,
      CSR_KEY   = 2'd3
   } csr_index_type;

   // Combination modes; codes 5..7 pass the tinted source through
   typedef enum logic [2:0] {
      MODE_BLEND  = 3'd0,
      MODE_ADD    = 3'd1,
      MODE_SUB    = 3'd2,
      MODE_MUL    = 3'd3,
      MODE_SCREEN = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0]  alpha;
      logic [15:0] tint;
      logic [2:0]  mode;
      logic [15:0] key;
   } cfg_type;

   // One colour channel, widened to six bits (red and blue use 5 of them)
   typedef logic [5:0]     chan_type;
   typedef chan_type [2:0] chans_type;   // [0] blue, [1] green, [2] red

   // Two products per channel, at most 63 * 255
   typedef logic [13:0]    prod_type;
   typedef prod_type [2:0] prods_type;

   typedef struct packed {
      logic [15:0] src;
      logic [15:0] dst;
      logic [15:0] addr;
      logic        last;
   } pix_in_type;

   // Side-band that travels unchanged down the pipe
   typedef struct packed {
      logic        we;      // 0 for a transparent source
      logic        copy;    // opaque and untinted: write source as is
      logic [15:0] src;
      logic [15:0] addr;
      logic        last;
   } meta_type;

   typedef struct packed {
      meta_type  meta;
      chans_type s;
      chans_type d;
   } tint_out_type;

   typedef struct packed {
      meta_type  meta;
      chans_type s;
      prods_type p0;
      prods_type p1;
   } prod_out_type;

   typedef struct packed {
      logic [15:0] result_pixel;
      logic        write_enable;
      logic [15:0] write_address;
      logic        last_out;
   } pix_out_type;

   // Channel maximum: 63 for green, 31 for red and blue
   function automatic chan_type chan_max(input int unsigned ch);
      return (ch == 1) ? 6'd63 : 6'd31;
   endfunction

   function automatic chans_type unpack_565(input logic [15:0] px);
      chans_type c;
      c[0] = {1'b0, px[4:0]};
      c[1] = px[10:5];
      c[2] = {1'b0, px[15:11]};
      return c;
   endfunction

   function automatic logic [15:0] pack_565(input chans_type c);
      return {c[2][4:0], c[1][5:0], c[0][4:0]};
   endfunction

endpackage

`default_nettype wire

[hdl/rgbbl_ifs.sv]
// Valid/ready channel interfaces of the RGB565 blend pipeline:
// pixel request, pixel response and register write. No dependencies.
`default_nettype none

interface rgbbl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] source_pixel;
   logic [15:0] dest_pixel;
   logic [15:0] pixel_address;
   logic        last_in_line;

   modport source (output valid, source_pixel, dest_pixel, pixel_address,
                   last_in_line, input ready);
   modport sink   (input valid, source_pixel, dest_pixel, pixel_address,
                   last_in_line, output ready);
endinterface

interface rgbbl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_pixel;
   logic        write_enable;
   logic [15:0] write_address;
   logic        last_out;

   modport source (output valid, result_pixel, write_enable, write_address,
                   last_out, input ready);
   modport sink   (input valid, result_pixel, write_enable, write_address,
                   last_out, output ready);
endinterface

interface rgbbl_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/rgbbl_tint.sv]
// Stage 1: transparent-key test, copy detection, channel split and tint.
// Depends on rgbbl_pkg.
`default_nettype none

module rgbbl_tint (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rgbbl_pkg::cfg_type    cfg,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire rgbbl_pkg::pix_in_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output rgbbl_pkg::tint_out_type    out_data
);
   import rgbbl_pkg::*;

   logic         valid_ff;
   tint_out_type data_ff;
   tint_out_type data_in;
   chans_type    src_ch;
   chans_type    tint_ch;
   logic         has_tint;

   assign src_ch   = unpack_565(in_data.src);
   assign tint_ch  = unpack_565(cfg.tint);
   assign has_tint = (cfg.tint != NO_COLOR);

   // side-band decisions
   always_comb begin
      data_in.meta.we   = !((cfg.key != NO_COLOR) && (in_data.src == cfg.key));
      data_in.meta.copy = (cfg.alpha == FULL_ALPHA) && !has_tint;
      data_in.meta.src  = in_data.src;
      data_in.meta.addr = in_data.addr;
      data_in.meta.last = in_data.last;
      data_in.d         = unpack_565(in_data.dst);
   end

   // per-channel tint: s * t / 32 (or / 64 for green)
   for (genvar i = 0; i < 3; i++) begin : g_tint
      localparam int SH = (i == 1) ? 6 : 5;
      logic [11:0] prod;
      assign prod         = src_ch[i] * tint_ch[i];
      assign data_in.s[i] = has_tint ? prod[SH +: 6] : src_ch[i];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rgbbl_prod.sv]
// Stage 2: the two per-channel products that the selected mode needs.
// Depends on rgbbl_pkg.
`default_nettype none

module rgbbl_prod (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rgbbl_pkg::cfg_type      cfg,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire rgbbl_pkg::tint_out_type in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output rgbbl_pkg::prod_out_type      out_data
);
   import rgbbl_pkg::*;

   logic         valid_ff;
   prod_out_type data_ff;
   prod_out_type data_in;

   assign data_in.meta = in_data.meta;
   assign data_in.s    = in_data.s;

   // operand selection and multiply, one pair per channel
   for (genvar i = 0; i < 3; i++) begin : g_prod
      localparam chan_type M = chan_max(i);
      chan_type   x0, x1;
      logic [7:0] y0, y1;

      always_comb begin
         x0 = in_data.s[i];
         y0 = cfg.alpha;
         x1 = in_data.d[i];
         y1 = 8'd0;
         case (cfg.mode) inside
            MODE_BLEND: begin
               y1 = FULL_ALPHA - cfg.alpha;
            end
            MODE_ADD, MODE_SUB: begin
               y1 = FULL_ALPHA;
            end
            MODE_MUL: begin
               x0 = in_data.d[i];
               y0 = {2'b00, in_data.s[i]};
            end
            MODE_SCREEN: begin
               x0 = M - in_data.d[i];
               y0 = {2'b00, M - in_data.s[i]};
            end
            default: begin
               y0 = 8'd0;
            end
         endcase
      end

      assign data_in.p0[i] = x0 * y0;
      assign data_in.p1[i] = x1 * y1;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rgbbl_mix.sv]
// Stage 3: sums, scaling and saturation per mode, packing, output register.
// Depends on rgbbl_pkg.
`default_nettype none

module rgbbl_mix (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rgbbl_pkg::cfg_type      cfg,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire rgbbl_pkg::prod_out_type in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output rgbbl_pkg::pix_out_type       out_data
);
   import rgbbl_pkg::*;

   logic        valid_ff;
   pix_out_type data_ff;
   pix_out_type data_in;
   chans_type   res;

   for (genvar i = 0; i < 3; i++) begin : g_mix
      localparam int       SH = (i == 1) ? 6 : 5;
      localparam chan_type M  = chan_max(i);
      logic [14:0] sum;
      logic [13:0] diff;
      logic [6:0]  sat_in;

      assign sum    = {1'b0, in_data.p0[i]} + {1'b0, in_data.p1[i]};
      assign diff   = (in_data.p1[i] > in_data.p0[i]) ?
                      (in_data.p1[i] - in_data.p0[i]) : 14'd0;
      assign sat_in = sum[14:8];

      always_comb begin
         case (cfg.mode)
            MODE_BLEND: begin
               res[i] = (cfg.alpha == FULL_ALPHA) ? in_data.s[i] : sum[13:8];
            end
            MODE_ADD: begin
               res[i] = (sat_in > {1'b0, M}) ? M : sat_in[5:0];
            end
            MODE_SUB: begin
               res[i] = diff[13:8];
            end
            MODE_MUL: begin
               res[i] = in_data.p0[i][SH +: 6];
            end
            MODE_SCREEN: begin
               res[i] = M - in_data.p0[i][SH +: 6];
            end
            default: begin
               res[i] = in_data.s[i];
            end
         endcase
      end
   end

   // transparent source writes nothing; opaque untinted copies the source
   always_comb begin
      if (!in_data.meta.we) begin
         data_in.result_pixel = 16'h0000;
      end else if (in_data.meta.copy) begin
         data_in.result_pixel = in_data.meta.src;
      end else begin
         data_in.result_pixel = pack_565(res);
      end
      data_in.write_enable  = in_data.meta.we;
      data_in.write_address = in_data.meta.addr;
      data_in.last_out      = in_data.meta.last;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rgb565_blend_pipeline.sv]
// RGB565 blend pipeline top level: register file and three pipeline stages.
// Depends on rgbbl_pkg, rgbbl_ifs, rgbbl_tint, rgbbl_prod and rgbbl_mix.
//
// Usage:
//   req_chan carries one request per pixel: source pixel, frame buffer pixel
//   at the target, its address and the last-of-line mark. rsp_chan returns
//   one result per request, in order: the pixel to store, a write enable
//   (low for a transparent source), the address and the last mark.
//   csr_chan writes alpha_level (0), tint_color (1), blend_select (2) and
//   transparent_key (3); it is always ready. Write registers only while no
//   request is in flight.
//   Path: an accepted request passes through three register stages (tint,
//   products, mix) and is then presented on rsp_chan.
//   Throughput: one pixel per clock while rsp_chan is not stalled; the tint
//   and products stages each hold one multiplier level, mix holds none.
//   Reset: empties the pipe and loads alpha 255, no tint, blend mode and
//   no transparent key.
//   Stall: while rsp_chan.ready is low the output holds its result; the
//   pipe keeps accepting until its three stages are full, then req_chan
//   ready drops. Nothing is lost or repeated.
`default_nettype none

module rgb565_blend_pipeline (
   input wire logic  clock,
   input wire logic  reset,
   rgbbl_req_if.sink   req_chan,
   rgbbl_rsp_if.source rsp_chan,
   rgbbl_csr_if.sink   csr_chan
);
   import rgbbl_pkg::*;

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   pix_in_type   pix_in;
   logic         s1_valid, s1_ready;
   tint_out_type s1_data;
   logic         s2_valid, s2_ready;
   prod_out_type s2_data;
   pix_out_type  s3_data;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ALPHA: cfg_in.alpha = csr_chan.data[7:0];
            CSR_TINT:  cfg_in.tint  = csr_chan.data;
            CSR_MODE:  cfg_in.mode  = csr_chan.data[2:0];
            CSR_KEY:   cfg_in.key   = csr_chan.data;
            default:   cfg_in       = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha <= FULL_ALPHA;
         cfg_ff.tint  <= NO_COLOR;
         cfg_ff.mode  <= MODE_BLEND;
         cfg_ff.key   <= NO_COLOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline
   assign pix_in.src  = req_chan.source_pixel;
   assign pix_in.dst  = req_chan.dest_pixel;
   assign pix_in.addr = req_chan.pixel_address;
   assign pix_in.last = req_chan.last_in_line;

   rgbbl_tint u_tint (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (pix_in),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   rgbbl_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rgbbl_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (s3_data)
   );

   assign rsp_chan.result_pixel  = s3_data.result_pixel;
   assign rsp_chan.write_enable  = s3_data.write_enable;
   assign rsp_chan.write_address = s3_data.write_address;
   assign rsp_chan.last_out      = s3_data.last_out;

   // checks
   a_transparent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.write_enable) |-> (rsp_chan.result_pixel == 16'h0000))
      else $error("transparent result carries a non-zero pixel");

   a_backpressure_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid && s2_valid && rsp_chan.valid && !rsp_chan.ready))
      else $error("request stalled while the pipe has room");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      (csr_chan.valid && csr_chan.ready && (csr_chan.index == CSR_MODE))
      |=> (cfg_ff.mode == $past(csr_chan.data[2:0])))
      else $error("mode register write lost");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && (cfg_ff.alpha == FULL_ALPHA) && (cfg_ff.key == NO_COLOR)))
      else $error("reset state wrong");

endmodule

`default_nettype wire

[tb/rgb565_blend_pipeline_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rgb565_blend_pipeline: directed and random pixel streams,
// predicted in SystemVerilog and checked in order. Needs rgbbl_pkg, rgbbl_ifs and the RTL.

module rgb565_blend_pipeline_test;
   import rgbbl_pkg::*;

   localparam int unsigned PIPE_LATENCY   = 3;
   localparam int unsigned RANDOM_PHASES  = 29;
   localparam int unsigned PHASE_PIXELS   = 50;
   localparam longint      TIMEOUT_NS     = 5_000_000;
   localparam int unsigned CHAN5_MAX      = 31;
   localparam int unsigned CHAN6_MAX      = 63;
   localparam int unsigned CHAN5_SCALE    = 32;
   localparam int unsigned CHAN6_SCALE    = 64;
   // Selector codes with no combination behind them
   localparam logic [2:0]  MODE_SPARE     = 3'd5;
   localparam logic [2:0]  MODE_SPARE_TOP = 3'd7;

   logic clock = 1'b0;
   logic reset;

   rgbbl_req_if req_chan ();
   rgbbl_rsp_if rsp_chan ();
   rgbbl_csr_if csr_chan ();

   rgb565_blend_pipeline dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // Register copy kept by the predictor
   logic [7:0]  cur_alpha;
   logic [15:0] cur_tint;
   logic [2:0]  cur_mode;
   logic [15:0] cur_key;

   pix_out_type pending_pixels [$];
   int unsigned fail_count       = 0;
   int unsigned pixels_checked   = 0;
   int unsigned pixels_skipped   = 0;
   int unsigned settings_applied = 0;
   bit          idle_enable      = 1'b1;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // One channel: s tinted source, d destination, m channel max, k scale
   function automatic int unsigned combine_channel(input int unsigned s, input int unsigned d,
                                                   input int unsigned m, input int unsigned k);
      int unsigned a;
      int unsigned v;
      int unsigned pos;
      int unsigned neg;
      a = cur_alpha;
      case (cur_mode)
         MODE_BLEND:  v = (a < FULL_ALPHA) ? (s * a + d * (FULL_ALPHA - a)) / 256 : s;
         MODE_ADD: begin
            v = (s * a + d * 255) / 256;
            if (v > m) v = m;
         end
         MODE_SUB: begin
            pos = d * 255;
            neg = s * a;
            v = (pos <= neg) ? 0 : (pos - neg) / 256;
         end
         MODE_MUL:    v = (d * s) / k;
         MODE_SCREEN: v = m - ((m - d) * (m - s)) / k;
         default:     v = s;
      endcase
      return v;
   endfunction

   function automatic pix_out_type predict_composite(input pix_in_type px);
      pix_out_type o;
      int unsigned r;
      int unsigned g;
      int unsigned b;
      o.result_pixel  = '0;
      o.write_enable  = 1'b1;
      o.write_address = px.addr;
      o.last_out      = px.last;
      if (cur_key != NO_COLOR && px.src == cur_key) begin
         o.write_enable = 1'b0;
      end else if (cur_alpha == FULL_ALPHA && cur_tint == NO_COLOR) begin
         o.result_pixel = px.src;
      end else begin
         r = px.src[4:0];
         g = px.src[10:5];
         b = px.src[15:11];
         if (cur_tint != NO_COLOR) begin
            r = r * cur_tint[4:0] / CHAN5_SCALE;
            g = g * cur_tint[10:5] / CHAN6_SCALE;
            b = b * cur_tint[15:11] / CHAN5_SCALE;
         end
         r = combine_channel(r, px.dst[4:0], CHAN5_MAX, CHAN5_SCALE);
         g = combine_channel(g, px.dst[10:5], CHAN6_MAX, CHAN6_SCALE);
         b = combine_channel(b, px.dst[15:11], CHAN5_MAX, CHAN5_SCALE);
         o.result_pixel = {b[4:0], g[5:0], r[4:0]};
      end
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Handshake helpers
   // ---------------------------------------------------------------

   // Mostly back to back, sometimes a short gap, now and then a long one; none with idle_enable off
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_pixel(input pix_in_type px);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.source_pixel  <= px.src;
      req_chan.dest_pixel    <= px.dst;
      req_chan.pixel_address <= px.addr;
      req_chan.last_in_line  <= px.last;
      do @(posedge clock); while (!req_chan.ready);
      pending_pixels.push_back(predict_composite(px));
   endtask

   task automatic send_fields(input logic [15:0] src, input logic [15:0] dst,
                              input logic [15:0] addr, input logic last);
      pix_in_type px;
      px.src  = src;
      px.dst  = dst;
      px.addr = addr;
      px.last = last;
      send_pixel(px);
   endtask

   // Stop sending and let every outstanding request come back
   task automatic settle_pipeline();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic set_register(input csr_index_type idx, input logic [15:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_ALPHA: cur_alpha = value[7:0];
         CSR_TINT:  cur_tint  = value;
         CSR_MODE:  cur_mode  = value[2:0];
         CSR_KEY:   cur_key   = value;
      endcase
   endtask

   // Writes all four registers; only call with the pipe settled
   task automatic apply_settings(input logic [15:0] alpha_word, input logic [15:0] tint_word,
                                 input logic [15:0] mode_word, input logic [15:0] key_word);
      set_register(CSR_ALPHA, alpha_word);
      set_register(CSR_TINT, tint_word);
      set_register(CSR_MODE, mode_word);
      set_register(CSR_KEY, key_word);
      csr_chan.valid <= 1'b0;
      settings_applied++;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset values: opaque untinted copy, and 0xFFFF is never transparent
   task automatic test_default_copy();
      send_fields(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
      send_fields(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
      send_fields(16'hF81F, 16'h07E0, 16'h5A5A, 1'b0);
      send_fields(16'h07E0, 16'hF81F, 16'hA5A5, 1'b1);
   endtask

   task automatic test_transparent_key();
      settle_pipeline();
      apply_settings(16'h0080, 16'hFFFF, 16'(MODE_BLEND), 16'h1234);
      send_fields(16'h1234, 16'hABCD, 16'h0010, 1'b0);
      send_fields(16'h1235, 16'hABCD, 16'h0011, 1'b1);
   endtask

   // Every combination mode and one spare selector code at half opacity, with saturating corners
   task automatic test_blend_modes();
      logic [2:0] codes [6];
      codes = '{MODE_BLEND, MODE_ADD, MODE_SUB, MODE_MUL, MODE_SCREEN, MODE_SPARE};
      foreach (codes[i]) begin
         settle_pipeline();
         apply_settings(16'h0080, 16'hFFFF, 16'(codes[i]), 16'hFFFF);
         send_fields(16'hFFFF, 16'hFFFF, 16'(i), 1'b0);
         send_fields(16'h0000, 16'hFFFF, 16'(i + 16), 1'b1);
      end
   endtask

   task automatic test_tint_and_alpha();
      // tint alone at full opacity
      settle_pipeline();
      apply_settings(16'h00FF, 16'h8410, 16'(MODE_BLEND), 16'hFFFF);
      send_fields(16'hFFFF, 16'h1234, 16'h0100, 1'b0);
      // full opacity and no tint copy the source in any mode; checked here in add mode
      settle_pipeline();
      apply_settings(16'h00FF, 16'hFFFF, 16'(MODE_ADD), 16'hFFFF);
      send_fields(16'h8421, 16'hFFFF, 16'h0101, 1'b0);
      // zero opacity blend, black tint: the destination scaled by 255/256
      settle_pipeline();
      apply_settings(16'h0000, 16'h0000, 16'(MODE_BLEND), 16'h0000);
      send_fields(16'hFFFF, 16'h9CE7, 16'h0102, 1'b1);
   endtask

   task automatic test_random_streams();
      logic [15:0] alpha_word;
      logic [15:0] tint_word;
      logic [15:0] mode_word;
      logic [15:0] key_word;
      int unsigned roll;
      pix_in_type  px;
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         idle_enable = (phase % 4 != 3);
         // upper bits of the alpha and mode writes are junk the block must ignore
         alpha_word = $urandom;
         mode_word  = $urandom;
         roll = $urandom_range(0, 9);
         case (roll)
            0:       alpha_word[7:0] = 8'd0;
            1, 2:    alpha_word[7:0] = FULL_ALPHA;
            3:       alpha_word[7:0] = 8'd1;
            4:       alpha_word[7:0] = 8'd254;
            default: alpha_word[7:0] = $urandom_range(0, 255);
         endcase
         roll = $urandom_range(0, 9);
         tint_word = (roll < 4) ? NO_COLOR : (roll == 4) ? 16'h0000 : 16'($urandom);
         mode_word[2:0] = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(MODE_BLEND, MODE_SCREEN))
                                                     : 3'($urandom_range(MODE_SPARE,
                                                                         MODE_SPARE_TOP));
         roll = $urandom_range(0, 9);
         key_word = (roll < 4) ? NO_COLOR : (roll == 4) ? 16'h0000 : 16'($urandom);
         apply_settings(alpha_word, tint_word, mode_word, key_word);
         for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
            roll = $urandom_range(0, 15);
            if (roll < 2) px.src = cur_key;
            else if (roll == 2) px.src = NO_COLOR;
            else px.src = $urandom;
            px.dst  = $urandom;
            px.addr = $urandom;
            px.last = ($urandom_range(0, 9) == 0);
            send_pixel(px);
         end
      end
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Result side: random back-pressure and in-order check
   // ---------------------------------------------------------------

   initial begin : response_stall
      int unsigned hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      $error("%s: expected %h, got %h", field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pix_out_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (!want.write_enable) pixels_skipped++;
            if (rsp_chan.result_pixel !== want.result_pixel)
               report_mismatch("result_pixel", want.result_pixel, rsp_chan.result_pixel);
            if (rsp_chan.write_enable !== want.write_enable)
               report_mismatch("write_enable", 16'(want.write_enable), 16'(rsp_chan.write_enable));
            if (rsp_chan.write_address !== want.write_address)
               report_mismatch("write_address", want.write_address, rsp_chan.write_address);
            if (rsp_chan.last_out !== want.last_out)
               report_mismatch("last_out", 16'(want.last_out), 16'(rsp_chan.last_out));
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin : main_sequence
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.source_pixel  <= '0;
      req_chan.dest_pixel    <= '0;
      req_chan.pixel_address <= '0;
      req_chan.last_in_line  <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= CSR_ALPHA;
      csr_chan.data          <= '0;
      cur_alpha = FULL_ALPHA;
      cur_tint  = NO_COLOR;
      cur_mode  = MODE_BLEND;
      cur_key   = NO_COLOR;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_copy();
      test_transparent_key();
      test_blend_modes();
      test_tint_and_alpha();
      test_random_streams();

      settle_pipeline();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $error("%0d expected responses never arrived", pending_pixels.size());
         fail_count++;
      end
      $display("Checked %0d composited pixels (%0d transparent) across %0d register settings,",
               pixels_checked, pixels_skipped, settings_applied);
      $display("covering all blend modes, spare selectors, tint, keying and back-pressure.");
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Safety net against a hung handshake
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
